/* design/rect_triangle_overlap_test_unit_assert.svh */
// Assertion macros shared by the overlap test unit.
`ifndef RECT_TRIANGLE_OVERLAP_TEST_UNIT_ASSERT_SVH
`define RECT_TRIANGLE_OVERLAP_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTO_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rto_pkg.sv */
`default_nettype none

package rto_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS_DEF = 16;

  // Triangle edges, each giving one candidate separating axis.
  localparam int NUM_EDGES = 3;

  // Result stream data width: overlap flag padded to one byte.
  localparam int M_TDATA_W = 8;

endpackage

`default_nettype wire

/* design/rto_in_stage.sv */
`default_nettype none

module rto_in_stage #(
  parameter int COORD_BITS = rto_pkg::COORD_BITS_DEF,
  localparam int CB        = COORD_BITS,
  localparam int IN_W      = 10 * COORD_BITS - 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [IN_W-1:0]      data_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic signed [CB-1:0]      rect_x_o,
  output logic signed [CB-1:0]      rect_y_o,
  output logic [CB-2:0]             rect_w_o,
  output logic [CB-2:0]             rect_h_o,
  output logic signed [2:0][CB-1:0] tri_x_o,
  output logic signed [2:0][CB-1:0] tri_y_o
);

  localparam int TB = 4 * CB - 2;

  logic            valid_q;
  logic [IN_W-1:0] data_q;

  // Accept a new transaction whenever the stage is empty or draining.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  // Hold the valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture the payload.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  // Split the packed word into fields.
  assign rect_x_o = data_q[CB-1:0];
  assign rect_y_o = data_q[2*CB-1:CB];
  assign rect_w_o = data_q[3*CB-2:2*CB];
  assign rect_h_o = data_q[4*CB-3:3*CB-1];

  for (genvar v = 0; v < 3; v++) begin : g_vtx
    assign tri_x_o[v] = data_q[TB+2*v*CB +: CB];
    assign tri_y_o[v] = data_q[TB+(2*v+1)*CB +: CB];
  end

endmodule

`default_nettype wire

/* design/rto_proj_stage.sv */
`default_nettype none

`include "rect_triangle_overlap_test_unit_assert.svh"

module rto_proj_stage #(
  parameter int COORD_BITS = rto_pkg::COORD_BITS_DEF,
  localparam int CB        = COORD_BITS,
  localparam int NE        = rto_pkg::NUM_EDGES,
  localparam int PW        = 2 * COORD_BITS + 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic signed [CB-1:0]        rect_x_i,
  input  wire logic signed [CB-1:0]        rect_y_i,
  input  wire logic [CB-2:0]               rect_w_i,
  input  wire logic [CB-2:0]               rect_h_i,
  input  wire logic signed [2:0][CB-1:0]   tri_x_i,
  input  wire logic signed [2:0][CB-1:0]   tri_y_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic                             sep_ax_o,
  output logic [NE-1:0][PW-1:0]            far_x_o,
  output logic [NE-1:0][PW-1:0]            far_y_o,
  output logic [NE-1:0][PW-1:0]            org_x_o,
  output logic [NE-1:0][PW-1:0]            org_y_o,
  output logic [NE-1:0][PW-1:0]            ext_w_o,
  output logic [NE-1:0][PW-1:0]            ext_h_o
);

  localparam int XW = PW - CB - 1;

  logic                  valid_q;
  logic                  sep_ax_d, sep_ax_q;
  logic [NE-1:0][PW-1:0] far_x_d, far_y_d, org_x_d, org_y_d, ext_w_d, ext_h_d;
  logic [NE-1:0][PW-1:0] far_x_q, far_y_q, org_x_q, org_y_q, ext_w_q, ext_h_q;

  logic signed [CB:0] rx, ry, rx_end, ry_end, w_ext, h_ext;
  logic signed [CB:0] tx [3];
  logic signed [CB:0] ty [3];
  logic signed [CB:0] tx_min, tx_max, ty_min, ty_max;

  // Widen rectangle and vertex coordinates by one bit.
  assign rx     = {rect_x_i[CB-1], rect_x_i};
  assign ry     = {rect_y_i[CB-1], rect_y_i};
  assign w_ext  = {2'b00, rect_w_i};
  assign h_ext  = {2'b00, rect_h_i};
  assign rx_end = rx + w_ext;
  assign ry_end = ry + h_ext;

  for (genvar v = 0; v < 3; v++) begin : g_widen
    assign tx[v] = {tri_x_i[v][CB-1], tri_x_i[v]};
    assign ty[v] = {tri_y_i[v][CB-1], tri_y_i[v]};
  end

  // Triangle bounding box for the two rectangle axes.
  always_comb begin
    tx_min = tx[0];
    tx_max = tx[0];
    ty_min = ty[0];
    ty_max = ty[0];
    for (int v = 1; v < 3; v++) begin
      if (tx[v] < tx_min) tx_min = tx[v];
      if (tx[v] > tx_max) tx_max = tx[v];
      if (ty[v] < ty_min) ty_min = ty[v];
      if (ty[v] > ty_max) ty_max = ty[v];
    end
  end

  assign sep_ax_d = (rx_end < tx_min) || (tx_max < rx) ||
                    (ry_end < ty_min) || (ty_max < ry);

  // Per edge: normal (-dy, dx) taken relative to the edge start vertex.
  for (genvar e = 0; e < NE; e++) begin : g_edge
    localparam int I = e;
    localparam int K = (e + 1) % NE;
    localparam int J = (e + 2) % NE;

    logic signed [CB:0] dx, dy, nx, ny, ex, ey, qx, qy;
    logic signed [PW-1:0] nx_w, ny_w, ex_w, ey_w, qx_w, qy_w, w_w, h_w;

    assign dx = tx[K] - tx[I];
    assign dy = ty[K] - ty[I];
    assign nx = ~dy + {{CB{1'b0}}, 1'b1};
    assign ny = dx;
    // Opposite vertex and rectangle origin, relative to the edge start.
    assign ex = tx[J] - tx[I];
    assign ey = ty[J] - ty[I];
    assign qx = rx - tx[I];
    assign qy = ry - ty[I];

    assign nx_w = {{XW{nx[CB]}}, nx};
    assign ny_w = {{XW{ny[CB]}}, ny};
    assign ex_w = {{XW{ex[CB]}}, ex};
    assign ey_w = {{XW{ey[CB]}}, ey};
    assign qx_w = {{XW{qx[CB]}}, qx};
    assign qy_w = {{XW{qy[CB]}}, qy};
    assign w_w  = {{XW{1'b0}}, w_ext};
    assign h_w  = {{XW{1'b0}}, h_ext};

    assign far_x_d[e] = nx_w * ex_w;
    assign far_y_d[e] = ny_w * ey_w;
    assign org_x_d[e] = nx_w * qx_w;
    assign org_y_d[e] = ny_w * qy_w;
    assign ext_w_d[e] = nx_w * w_w;
    assign ext_h_d[e] = ny_w * h_w;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  // Hold the valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Register the products.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sep_ax_q <= sep_ax_d;
      far_x_q  <= far_x_d;
      far_y_q  <= far_y_d;
      org_x_q  <= org_x_d;
      org_y_q  <= org_y_d;
      ext_w_q  <= ext_w_d;
      ext_h_q  <= ext_h_d;
    end
  end

  assign sep_ax_o = sep_ax_q;
  assign far_x_o  = far_x_q;
  assign far_y_o  = far_y_q;
  assign org_x_o  = org_x_q;
  assign org_y_o  = org_y_q;
  assign ext_w_o  = ext_w_q;
  assign ext_h_o  = ext_h_q;

  `RTO_ASSERT_NEXT(a_proj_load, clk_i, rst_ni, valid_i && ready_o, valid_o, "product stage lost a transaction")
  `RTO_ASSERT_NOW(a_proj_stall, clk_i, rst_ni, !ready_o, valid_o && !ready_i, "product stage stalled while empty")

endmodule

`default_nettype wire

/* design/rto_sep_stage.sv */
`default_nettype none

`include "rect_triangle_overlap_test_unit_assert.svh"

module rto_sep_stage #(
  parameter int COORD_BITS = rto_pkg::COORD_BITS_DEF,
  localparam int NE        = rto_pkg::NUM_EDGES,
  localparam int PW        = 2 * COORD_BITS + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic                  sep_ax_i,
  input  wire logic [NE-1:0][PW-1:0] far_x_i,
  input  wire logic [NE-1:0][PW-1:0] far_y_i,
  input  wire logic [NE-1:0][PW-1:0] org_x_i,
  input  wire logic [NE-1:0][PW-1:0] org_y_i,
  input  wire logic [NE-1:0][PW-1:0] ext_w_i,
  input  wire logic [NE-1:0][PW-1:0] ext_h_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic                       overlap_o
);

  localparam int SW = PW + 2;

  logic          valid_q;
  logic          overlap_d, overlap_q;
  logic [NE-1:0] sep_edge;

  // Edge axes: triangle spans [min(0,d), max(0,d)], rectangle spans
  // p plus the negative or positive parts of the two extent products.
  // A zero normal collapses both spans to zero and never separates.
  for (genvar e = 0; e < NE; e++) begin : g_edge
    logic signed [SW-1:0] fx, fy, ox, oy, ew, eh, d, p;
    logic signed [SW-1:0] t_lo, t_hi, r_lo, r_hi, ew_neg, ew_pos, eh_neg, eh_pos;

    assign fx = {{2{far_x_i[e][PW-1]}}, far_x_i[e]};
    assign fy = {{2{far_y_i[e][PW-1]}}, far_y_i[e]};
    assign ox = {{2{org_x_i[e][PW-1]}}, org_x_i[e]};
    assign oy = {{2{org_y_i[e][PW-1]}}, org_y_i[e]};
    assign ew = {{2{ext_w_i[e][PW-1]}}, ext_w_i[e]};
    assign eh = {{2{ext_h_i[e][PW-1]}}, ext_h_i[e]};

    assign d = fx + fy;
    assign p = ox + oy;

    assign t_lo   = d[SW-1] ? d : '0;
    assign t_hi   = d[SW-1] ? '0 : d;
    assign ew_neg = ew[SW-1] ? ew : '0;
    assign ew_pos = ew[SW-1] ? '0 : ew;
    assign eh_neg = eh[SW-1] ? eh : '0;
    assign eh_pos = eh[SW-1] ? '0 : eh;
    assign r_lo   = p + ew_neg + eh_neg;
    assign r_hi   = p + ew_pos + eh_pos;

    assign sep_edge[e] = (r_hi < t_lo) || (t_hi < r_lo);
  end

  assign overlap_d = !(sep_ax_i || (|sep_edge));

  assign ready_o   = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign overlap_o = overlap_q;

  // Hold the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Register the verdict.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      overlap_q <= overlap_d;
    end
  end

  `RTO_ASSERT_NEXT(a_sep_load, clk_i, rst_ni, valid_i && ready_o, valid_o, "result stage lost a transaction")
  `RTO_ASSERT_NEXT(a_sep_axis, clk_i, rst_ni, valid_i && ready_o && sep_ax_i, !overlap_o, "separated box reported as overlap")

endmodule

`default_nettype wire

/* design/rect_triangle_overlap_test_unit.sv */
// Rectangle/triangle overlap test by separating axes. Each input transaction
// carries an axis-aligned rectangle (corner, width, height) and a triangle;
// the single result transaction carries 1 when the shapes intersect or touch
// and 0 when the rectangle axes or one of the triangle's edge normals separate
// them. The unit accepts one transaction per cycle while the output is not
// stalled and returns results in order through three register stages
// (input capture, edge-normal products, interval compare and result).
// Arithmetic is exact for every input, so no clamping occurs.

`default_nettype none

`include "rect_triangle_overlap_test_unit_assert.svh"

module rect_triangle_overlap_test_unit #(
  parameter int COORD_BITS  = rto_pkg::COORD_BITS_DEF,
  localparam int IN_W       = 10 * COORD_BITS - 2,
  localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // rect_x, rect_y, rect_w, rect_h, tri_ax, tri_ay, tri_bx, tri_by,
  // tri_cx, tri_cy, zero padding
  input  wire logic [S_TDATA_W-1:0]         s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // overlaps, zero padding
  output logic [rto_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int CB = COORD_BITS;
  localparam int NE = rto_pkg::NUM_EDGES;
  localparam int PW = 2 * COORD_BITS + 2;

  logic                  in_valid, in_ready;
  logic signed [CB-1:0]  rect_x, rect_y;
  logic [CB-2:0]         rect_w, rect_h;
  logic signed [2:0][CB-1:0] tri_x, tri_y;

  logic                  prod_valid, prod_ready;
  logic                  sep_ax;
  logic [NE-1:0][PW-1:0] far_x, far_y, org_x, org_y, ext_w, ext_h;

  logic                  overlap;

  // Capture the incoming transaction.
  rto_in_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .data_i   (s_axis_tdata_i[IN_W-1:0]),
    .valid_o  (in_valid),
    .ready_i  (in_ready),
    .rect_x_o (rect_x),
    .rect_y_o (rect_y),
    .rect_w_o (rect_w),
    .rect_h_o (rect_h),
    .tri_x_o  (tri_x),
    .tri_y_o  (tri_y)
  );

  // Form edge normals and their dot products.
  rto_proj_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .ready_o  (in_ready),
    .rect_x_i (rect_x),
    .rect_y_i (rect_y),
    .rect_w_i (rect_w),
    .rect_h_i (rect_h),
    .tri_x_i  (tri_x),
    .tri_y_i  (tri_y),
    .valid_o  (prod_valid),
    .ready_i  (prod_ready),
    .sep_ax_o (sep_ax),
    .far_x_o  (far_x),
    .far_y_o  (far_y),
    .org_x_o  (org_x),
    .org_y_o  (org_y),
    .ext_w_o  (ext_w),
    .ext_h_o  (ext_h)
  );

  // Compare intervals and register the verdict.
  rto_sep_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_sep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (prod_valid),
    .ready_o   (prod_ready),
    .sep_ax_i  (sep_ax),
    .far_x_i   (far_x),
    .far_y_i   (far_y),
    .org_x_i   (org_x),
    .org_y_i   (org_y),
    .ext_w_i   (ext_w),
    .ext_h_i   (ext_h),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .overlap_o (overlap)
  );

  assign m_axis_tdata_o = {{(rto_pkg::M_TDATA_W - 1){1'b0}}, overlap};

  `RTO_ASSERT_NOW(a_top_backpressure, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output backpressure")

endmodule

`default_nettype wire
